### sv/fstg_pkg.sv
// Shared types, constants and the quarter-wave sine table builder for the tone generator.
package fstg_pkg;

  // Fixed widths of the datapath.
  localparam int PHASE_BITS      = 32;
  localparam int TABLE_ADDR_BITS = 10;
  localparam int SAMPLE_BITS     = 16;
  localparam int MAG_BITS        = SAMPLE_BITS - 1;
  localparam int TIME_BITS       = 64;
  localparam int CFG_DATA_BITS   = 64;
  localparam int CFG_INDEX_BITS  = 2;
  localparam int FRAME_LEN_BITS  = 12;
  localparam int POS_BITS        = 11;
  localparam int MAX_FRAME       = 2048;

  // The quarter-wave table holds one entry more than a power of two so that
  // the fold at the quadrant edge can address the peak value.
  localparam int QTR_SIZE      = 1 << TABLE_ADDR_BITS;
  localparam int QTR_ENTRIES   = QTR_SIZE + 1;
  localparam int ROM_ADDR_BITS = TABLE_ADDR_BITS + 1;

  // Request codes.
  localparam logic REQ_START  = 1'b0;
  localparam logic REQ_SAMPLE = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_BITS-1:0] REG_PHASE_STEP   = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_LEN    = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_PERIOD = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [PHASE_BITS-1:0]     PHASE_STEP_RST   = 32'd89478485;
  localparam logic [FRAME_LEN_BITS-1:0] FRAME_LEN_RST    = 12'd480;
  localparam logic [TIME_BITS-1:0]      FRAME_PERIOD_RST = 64'd10000000;

  // Table generation constants: pi/2 in Q30 and the Taylor term divisors.
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] TAYLOR_DIV [1:7] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                               64'd110, 64'd156, 64'd210};
  localparam int          ROUND_SHIFT = 30 - MAG_BITS;
  localparam logic [63:0] ROUND_HALF  = 64'd1 << (ROUND_SHIFT - 1);
  localparam logic [63:0] SAMPLE_SAT  = (64'd1 << MAG_BITS) - 64'd1;

  typedef logic [MAG_BITS-1:0] qtr_rom_t [QTR_ENTRIES];

  // One table entry: sin(pi/2 * k / N) by a truncating Q30 Taylor series,
  // rounded half up to the sample fraction and saturated.
  function automatic logic [MAG_BITS-1:0] quarter_sine(input logic [ROM_ADDR_BITS-1:0] k);
    logic [63:0] theta;
    logic [63:0] theta2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] r;
    theta  = (HALF_PI_Q30 * 64'(k)) >> TABLE_ADDR_BITS;
    theta2 = (theta * theta) >> 30;
    term   = theta;
    sum    = theta;
    for (int i = 1; i <= 7; i++) begin
      term = ((term * theta2) >> 30) / TAYLOR_DIV[i];
      if ((i & 1) == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    r = (sum + ROUND_HALF) >> ROUND_SHIFT;
    if (r > SAMPLE_SAT) begin
      r = SAMPLE_SAT;
    end
    return r[MAG_BITS-1:0];
  endfunction

  // Whole quarter-wave table, evaluated at elaboration.
  function automatic qtr_rom_t build_qtr_rom();
    qtr_rom_t rom;
    for (int k = 0; k < QTR_ENTRIES; k++) begin
      rom[k] = quarter_sine(ROM_ADDR_BITS'(k));
    end
    return rom;
  endfunction

endpackage

### sv/fstg_if.sv
// Request and result channel interfaces of the tone generator.
interface fstg_req_if import fstg_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic                 req_type;
  logic [TIME_BITS-1:0] now_time;

  modport source (output valid, req_type, now_time, input ready);
  modport sink (input valid, req_type, now_time, output ready);
endinterface

interface fstg_res_if import fstg_pkg::*;;
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          sample_valid;
  logic                          frame_last;

  modport source (output valid, sample, sample_valid, frame_last, input ready);
  modport sink (input valid, sample, sample_valid, frame_last, output ready);
endinterface

### sv/framed_sine_tone_generator_top.sv
// Framed sine tone generator: one result per request, one request per cycle unless results stall.
// Each request transaction produces exactly one result transaction. A start request clears
// the phase and frame position and sets the frame due time to the request timestamp; a
// sample request returns the sine of the phase accumulator from a quarter-wave table and
// steps the phase, unless it opens a frame whose due time has not been reached. The block
// accepts one request per clock cycle while the result side does not stall. An accepted request
// goes through the state update and the registered read of the 1025-entry sine table, then
// through the sign fold into the output register. When the result side stalls, the request side
// keeps accepting until both pipeline registers are full.
module framed_sine_tone_generator_top import fstg_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  fstg_req_if.sink                  req,
  fstg_res_if.source                res
);

  localparam qtr_rom_t QTR_ROM = build_qtr_rom();

  // Configuration registers.
  logic [PHASE_BITS-1:0]     phase_step;
  logic [FRAME_LEN_BITS-1:0] samples_per_frame;
  logic [TIME_BITS-1:0]      frame_period_ticks;

  // Generator state.
  logic [PHASE_BITS-1:0] phase_acc;
  logic [POS_BITS-1:0]   frame_pos;
  logic [TIME_BITS-1:0]  due_time;

  // First pipeline stage.
  logic                s1_valid;
  logic                s1_smp_valid;
  logic                s1_last;
  logic                s1_neg;
  logic [MAG_BITS-1:0] rom_q;

  logic                      accept;
  logic                      s1_adv;
  logic                      is_start;
  logic                      not_due;
  logic                      do_sample;
  logic [FRAME_LEN_BITS-1:0] frame_len;
  logic [FRAME_LEN_BITS-1:0] pos_inc;
  logic                      at_last;
  logic [1:0]                quad;
  logic [TABLE_ADDR_BITS-1:0] tbl_idx;
  logic [ROM_ADDR_BITS-1:0]  rom_addr;
  logic signed [SAMPLE_BITS-1:0] s1_sample;

  // Configuration writes; indexes beyond the register list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step         <= PHASE_STEP_RST;
      samples_per_frame  <= FRAME_LEN_RST;
      frame_period_ticks <= FRAME_PERIOD_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PHASE_STEP:   phase_step         <= cfg_data[PHASE_BITS-1:0];
        REG_FRAME_LEN:    samples_per_frame  <= cfg_data[FRAME_LEN_BITS-1:0];
        REG_FRAME_PERIOD: frame_period_ticks <= cfg_data[TIME_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Handshake: stage one moves on when the output register is free or being taken.
  assign s1_adv    = !res.valid || res.ready;
  assign req.ready = !s1_valid || s1_adv;
  assign accept    = req.valid && req.ready;

  // Request decode and frame bookkeeping.
  assign is_start  = (req.req_type == REQ_START);
  assign not_due   = (frame_pos == '0) && (req.now_time < due_time);
  assign do_sample = !is_start && !not_due;

  // Effective frame length: zero acts as one, long frames clamp to the maximum.
  always_comb begin
    priority if (samples_per_frame == '0) begin
      frame_len = FRAME_LEN_BITS'(1);
    end else if (samples_per_frame > FRAME_LEN_BITS'(MAX_FRAME)) begin
      frame_len = FRAME_LEN_BITS'(MAX_FRAME);
    end else begin
      frame_len = samples_per_frame;
    end
  end

  assign pos_inc = {1'b0, frame_pos} + FRAME_LEN_BITS'(1);
  assign at_last = (pos_inc >= frame_len);

  // Quadrant fold of the current phase into a quarter-wave table address.
  assign quad     = phase_acc[PHASE_BITS-1 -: 2];
  assign tbl_idx  = phase_acc[PHASE_BITS-3 -: TABLE_ADDR_BITS];
  assign rom_addr = quad[0] ? (ROM_ADDR_BITS'(QTR_SIZE) - {1'b0, tbl_idx})
                            : {1'b0, tbl_idx};

  // State update on each accepted request transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_acc <= '0;
      frame_pos <= '0;
      due_time  <= '0;
    end else if (accept) begin
      if (is_start) begin
        phase_acc <= '0;
        frame_pos <= '0;
        due_time  <= req.now_time;
      end else if (do_sample) begin
        phase_acc <= phase_acc + phase_step;
        if (at_last) begin
          frame_pos <= '0;
          due_time  <= due_time + frame_period_ticks;
        end else begin
          frame_pos <= pos_inc[POS_BITS-1:0];
        end
      end
    end
  end

  // Stage one control.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  // Stage one payload and registered table read.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_smp_valid <= do_sample;
      s1_last      <= do_sample && at_last;
      s1_neg       <= quad[1];
      rom_q        <= QTR_ROM[rom_addr];
    end
  end

  // Sign fold; invalid results carry a zero sample.
  always_comb begin
    if (!s1_smp_valid) begin
      s1_sample = '0;
    end else if (s1_neg) begin
      s1_sample = -$signed({1'b0, rom_q});
    end else begin
      s1_sample = $signed({1'b0, rom_q});
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (s1_adv) begin
      res.valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid) begin
      res.sample       <= s1_sample;
      res.sample_valid <= s1_smp_valid;
      res.frame_last   <= s1_last;
    end
  end

endmodule

### sv/fstg_checker.sv
// Port-level checker for the tone generator and its bind to the top level.
module fstg_checker import fstg_pkg::*; (
  input logic                          clk,
  input logic                          rst,
  input logic                          res_valid,
  input logic                          res_ready,
  input logic signed [SAMPLE_BITS-1:0] sample,
  input logic                          sample_valid,
  input logic                          frame_last
);

  // No result is offered in the cycle after reset.
  a_reset_quiet: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid right after reset");

  // A result without a sample carries a zero sample and no frame end.
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !sample_valid) |-> (sample == '0 && !frame_last))
    else $error("result without sample has nonzero payload");

  // The sine magnitude is saturated, so the most negative code never appears.
  a_no_min_code: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (sample != {1'b1, {(SAMPLE_BITS-1){1'b0}}}))
    else $error("sample holds the most negative code");

  // A stalled result transaction keeps its payload.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=>
      (res_valid && $stable(sample) && $stable(sample_valid) && $stable(frame_last)))
    else $error("stalled result changed");

endmodule

bind framed_sine_tone_generator_top fstg_checker u_fstg_checker (
  .clk          (clk),
  .rst          (rst),
  .res_valid    (res.valid),
  .res_ready    (res.ready),
  .sample       (res.sample),
  .sample_valid (res.sample_valid),
  .frame_last   (res.frame_last)
);

### sim/testbench.sv
// Self-checking testbench for the framed sine tone generator top level.
`timescale 1ns / 1ps

module testbench;
  import fstg_pkg::*;

  localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

  // One result transaction as the generator should produce it.
  typedef struct {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          sample_valid;
    logic                          frame_last;
  } tone_result_t;

  // Predicts the tone stream from accepted requests and checks returned results.
  class tone_scoreboard;
    logic [MAG_BITS-1:0]       sine_mag [QTR_ENTRIES];
    tone_result_t              tone_queue [$];
    logic [PHASE_BITS-1:0]     phase_step;
    logic [FRAME_LEN_BITS-1:0] frame_len;
    logic [TIME_BITS-1:0]      frame_period;
    logic [PHASE_BITS-1:0]     phase_acc;
    logic [POS_BITS-1:0]       frame_pos;
    logic [TIME_BITS-1:0]      due_at;
    int                        errors;

    function new();
      for (int k = 0; k < QTR_ENTRIES; k++) begin
        sine_mag[k] = sine_entry(k);
      end
      phase_step   = PHASE_STEP_RST;
      frame_len    = FRAME_LEN_RST;
      frame_period = FRAME_PERIOD_RST;
      phase_acc    = '0;
      frame_pos    = '0;
      due_at       = '0;
      errors       = 0;
    endfunction

    // Quarter-wave magnitude: Q30 angle, seven truncating Taylor terms, rounded to Q15.
    function logic [MAG_BITS-1:0] sine_entry(int k);
      longint unsigned ang;
      longint unsigned ang_sq;
      longint unsigned term;
      longint unsigned acc;
      ang    = (64'd1686629713 * 64'(k)) >> TABLE_ADDR_BITS;
      ang_sq = (ang * ang) >> 30;
      term   = ang;
      acc    = ang;
      for (int n = 1; n <= 7; n++) begin
        term = ((term * ang_sq) >> 30) / 64'(2 * n * (2 * n + 1));
        acc  = (n % 2 == 1) ? acc - term : acc + term;
      end
      acc = (acc + (64'd1 << (29 - MAG_BITS))) >> (30 - MAG_BITS);
      if (acc > (64'd1 << MAG_BITS) - 64'd1) begin
        acc = (64'd1 << MAG_BITS) - 64'd1;
      end
      return acc[MAG_BITS-1:0];
    endfunction

    function void set_config(logic [PHASE_BITS-1:0] step, logic [FRAME_LEN_BITS-1:0] len,
                             logic [TIME_BITS-1:0] period);
      phase_step   = step;
      frame_len    = len;
      frame_period = period;
    endfunction

    function int pending();
      return tone_queue.size();
    endfunction

    // Advances the generator state for one accepted request and queues its result.
    function void note_request(logic req_type, logic [TIME_BITS-1:0] now_time);
      tone_result_t                  r;
      int                            eff_len;
      int                            addr;
      logic [1:0]                    quad;
      logic [TABLE_ADDR_BITS-1:0]    idx;
      logic signed [SAMPLE_BITS-1:0] mag;
      r.sample       = '0;
      r.sample_valid = 1'b0;
      r.frame_last   = 1'b0;
      if (req_type == REQ_START) begin
        phase_acc = '0;
        frame_pos = '0;
        due_at    = now_time;
      end else if (!(frame_pos == '0 && now_time < due_at)) begin
        eff_len = int'(frame_len);
        if (eff_len == 0) begin
          eff_len = 1;
        end else if (eff_len > MAX_FRAME) begin
          eff_len = MAX_FRAME;
        end
        // Fold the phase onto the quarter wave and restore the sign.
        quad = phase_acc[PHASE_BITS-1 -: 2];
        idx  = phase_acc[PHASE_BITS-3 -: TABLE_ADDR_BITS];
        addr = quad[0] ? QTR_SIZE - int'(idx) : int'(idx);
        mag  = {1'b0, sine_mag[addr]};
        r.sample       = quad[1] ? -mag : mag;
        r.sample_valid = 1'b1;
        phase_acc      = phase_acc + phase_step;
        if (int'(frame_pos) + 1 >= eff_len) begin
          r.frame_last = 1'b1;
          frame_pos    = '0;
          due_at       = due_at + frame_period;
        end else begin
          frame_pos = frame_pos + 1'b1;
        end
      end
      tone_queue.push_back(r);
    endfunction

    task report(string what);
      if (errors < 200) begin
        $display("MISMATCH at %0t: %s", $realtime, what);
      end
      errors++;
    endtask

    // Compares one result transaction with the oldest prediction.
    task check_result(logic signed [SAMPLE_BITS-1:0] sample, logic sample_valid,
                      logic frame_last);
      tone_result_t e;
      if (tone_queue.size() == 0) begin
        report("result transaction with no request waiting");
      end else begin
        e = tone_queue.pop_front();
        if (sample !== e.sample) begin
          report($sformatf("sample %0d, expected %0d", sample, e.sample));
        end
        if (sample_valid !== e.sample_valid) begin
          report($sformatf("sample_valid %b, expected %b", sample_valid, e.sample_valid));
        end
        if (frame_last !== e.frame_last) begin
          report($sformatf("frame_last %b, expected %b", frame_last, e.frame_last));
        end
      end
    endtask
  endclass

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cfg_we;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_data;
  logic                      rx_block = 1'b0;
  logic                      rx_stall_on = 1'b0;
  bit                        tx_idle_on;
  int                        rx_wait;
  int                        items_sent;

  tone_scoreboard sb = new();

  fstg_req_if req_ch ();
  fstg_res_if res_ch ();

  framed_sine_tone_generator_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req_ch),
    .res       (res_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Result side: random stalls after each transaction, plus the long hold-off.
  always @(posedge clk) begin
    if (rst) begin
      rx_wait = 0;
      res_ch.ready <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        rx_wait = rx_stall_on ? $urandom_range(0, 6) : 0;
      end else if (rx_wait > 0) begin
        rx_wait--;
      end
      res_ch.ready <= !rx_block && rx_wait == 0;
    end
  end

  // Every accepted result goes to the checker.
  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready) begin
      sb.check_result(res_ch.sample, res_ch.sample_valid, res_ch.frame_last);
    end
  end

  function automatic logic [TIME_BITS-1:0] rand_time();
    return {$urandom, $urandom};
  endfunction

  // Offers one request transaction and returns at the edge that accepts it.
  task automatic send_req(input logic req_type, input logic [TIME_BITS-1:0] now_time);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.req_type <= req_type;
    req_ch.now_time <= now_time;
    do @(posedge clk); while (!req_ch.ready);
    sb.note_request(req_type, now_time);
    items_sent++;
  endtask

  // Stops offering and waits until every predicted result has come back.
  task automatic drain();
    req_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic load_config(input logic [PHASE_BITS-1:0] step,
                             input logic [FRAME_LEN_BITS-1:0] len,
                             input logic [TIME_BITS-1:0] period);
    cfg_we    <= 1'b1;
    cfg_index <= REG_PHASE_STEP;
    cfg_data  <= CFG_DATA_BITS'(step);
    @(posedge clk);
    cfg_index <= REG_FRAME_LEN;
    cfg_data  <= CFG_DATA_BITS'(len);
    @(posedge clk);
    cfg_index <= REG_FRAME_PERIOD;
    cfg_data  <= period;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_config(step, len, period);
  endtask

  // Well-formed framing: mostly sample requests timed around the next frame due time.
  task automatic run_frames(input int n_items);
    logic [TIME_BITS-1:0] t;
    if ($urandom_range(0, 9) < 7) begin
      case ($urandom_range(0, 2))
        0:       t = TIME_MAX - TIME_BITS'($urandom_range(0, 300));
        1:       t = TIME_BITS'($urandom_range(0, 1000));
        default: t = rand_time();
      endcase
      send_req(REQ_START, t);
    end
    for (int i = 1; i < n_items; i++) begin
      if ($urandom_range(0, 24) == 0) begin
        send_req(REQ_START, rand_time());
      end else if ($urandom_range(0, 9) == 0) begin
        send_req(REQ_SAMPLE, rand_time());
      end else begin
        t = sb.due_at + TIME_BITS'($urandom_range(0, 80)) - TIME_BITS'(40);
        send_req(REQ_SAMPLE, t);
      end
    end
  endtask

  task automatic run_noise(input int n_items);
    for (int i = 0; i < n_items; i++) begin
      send_req(logic'($urandom_range(0, 1)), rand_time());
    end
  endtask

  task automatic random_config();
    logic [PHASE_BITS-1:0]     step;
    logic [FRAME_LEN_BITS-1:0] len;
    logic [TIME_BITS-1:0]      period;
    case ($urandom_range(0, 5))
      0:       step = '0;
      1:       step = 32'h8000_0000;
      2:       step = $urandom;
      default: step = $urandom_range(1, 32'h0400_0000);
    endcase
    case ($urandom_range(0, 7))
      0:       len = '0;
      1:       len = 12'd1;
      2:       len = 12'd2048;
      3:       len = FRAME_LEN_BITS'($urandom_range(2049, 4095));
      4:       len = FRAME_LEN_BITS'($urandom_range(0, 4095));
      default: len = FRAME_LEN_BITS'($urandom_range(1, 12));
    endcase
    case ($urandom_range(0, 5))
      0:       period = TIME_BITS'(1);
      1:       period = TIME_MAX;
      2:       period = rand_time();
      default: period = TIME_BITS'($urandom_range(1, 200));
    endcase
    load_config(step, len, period);
  endtask

  // Main sequence: reset, directed cases, the long hold-off, then random phases.
  initial begin
    req_ch.valid    = 1'b0;
    req_ch.req_type = REQ_START;
    req_ch.now_time = '0;
    res_ch.ready    = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = REG_PHASE_STEP;
    cfg_data        = '0;
    tx_idle_on      = 1'b0;
    items_sent      = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset configuration; requests before any start run against a due time of zero.
    send_req(REQ_SAMPLE, '0);
    send_req(REQ_SAMPLE, TIME_MAX);
    send_req(REQ_START, TIME_BITS'(5));
    send_req(REQ_SAMPLE, TIME_BITS'(4));
    drain();

    // Quarter-turn steps visit every quadrant and both table ends; frame not yet due.
    load_config(32'h4000_0000, 12'd2, TIME_BITS'(1000));
    send_req(REQ_START, TIME_BITS'(1000));
    send_req(REQ_SAMPLE, TIME_BITS'(1000));
    send_req(REQ_SAMPLE, '0);
    send_req(REQ_SAMPLE, TIME_BITS'(1999));
    send_req(REQ_SAMPLE, TIME_BITS'(2000));
    send_req(REQ_SAMPLE, TIME_BITS'(2000));
    drain();

    // Zero frame length acts as one; the largest period makes the due time wrap.
    load_config(32'h8000_0000, 12'd0, TIME_MAX);
    send_req(REQ_START, TIME_BITS'(10));
    send_req(REQ_SAMPLE, TIME_BITS'(10));
    send_req(REQ_SAMPLE, TIME_BITS'(8));
    send_req(REQ_SAMPLE, TIME_BITS'(9));
    send_req(REQ_START, TIME_MAX - 15);
    send_req(REQ_SAMPLE, TIME_MAX - 15);
    send_req(REQ_SAMPLE, TIME_MAX - 17);
    drain();

    // Oversized frame length saturates; a zero step holds the phase.
    load_config('0, 12'd4095, TIME_BITS'(1));
    send_req(REQ_START, '0);
    send_req(REQ_SAMPLE, '0);
    drain();

    // Frame length lowered in the middle of a frame ends it at the next sample.
    load_config(32'hFFFF_FFFF, 12'd8, TIME_BITS'(1));
    send_req(REQ_START, '0);
    repeat (4) send_req(REQ_SAMPLE, TIME_BITS'(3));
    drain();
    load_config(32'hFFFF_FFFF, 12'd3, TIME_BITS'(1));
    send_req(REQ_SAMPLE, TIME_BITS'(3));
    send_req(REQ_SAMPLE, TIME_BITS'(3));
    drain();

    // Result side held off while requests keep coming, so the input stalls.
    load_config(32'd89478485, 12'd5, TIME_BITS'(50));
    tx_idle_on = 1'b0;
    rx_stall_on <= 1'b0;
    fork
      begin
        @(posedge clk);
        rx_block <= 1'b1;
        repeat (80) @(posedge clk);
        rx_block <= 1'b0;
      end
      run_frames(40);
    join
    drain();

    // Random phases, each with its own configuration and idle pattern.
    while (items_sent < 650) begin
      random_config();
      tx_idle_on = $urandom_range(0, 3) != 0;
      rx_stall_on <= $urandom_range(0, 3) != 0;
      if ($urandom_range(0, 3) == 0) begin
        run_noise($urandom_range(15, 50));
      end else begin
        run_frames($urandom_range(15, 50));
      end
      drain();
    end

    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog far beyond the slowest legal run.
  initial begin
    #2_400_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
